// ===== rtl/core/particle_pool_update_core_assert.svh =====
// assertion macros for the particle pool core
`ifndef PARTICLE_POOL_UPDATE_CORE_ASSERT_SVH
`define PARTICLE_POOL_UPDATE_CORE_ASSERT_SVH

// property that holds on every edge outside reset
`define PPU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the next cycle
`define PPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// shared types and constants of the particle pool core
// ----------------------------------------------------------------------------
package ppu_pkg;
  localparam int unsigned PoolSize = 1024;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CntW = 11;

  typedef enum logic [1:0] {
    OpEmit = 2'd0,
    OpTick = 2'd1,
    OpRead = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef struct packed {
    logic               active;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [31:0] begin_rgba;
    logic [31:0] end_rgba;
    logic [31:0] cur_rgba;
    logic [15:0] begin_size;
    logic [15:0] end_size;
    logic [15:0] cur_size;
    logic [15:0] life_span;
    logic signed [16:0] life_left;
  } rec_t;

  // stored slot layout
  localparam int unsigned RecW = $bits(rec_t);

  // divider control
  typedef struct packed {
    logic        start;
    logic [32:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;
  } div_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage

// ===== rtl/core/ppu_ram.sv =====
// ----------------------------------------------------------------------------
// ppu_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ppu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/core/ppu_div.sv =====
// ----------------------------------------------------------------------------
// ppu_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ppu_div import ppu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [32:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    cnt_d = cnt_q; run_d = run_q; done_d = 1'b0;
    trial = {rem_q, quo_q[32]} - {2'b00, den_q};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = 6'd33; run_d = 1'b1;
    end else if (run_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[32]};
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      run_q <= run_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

// ===== rtl/core/particle_pool_update_core.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update_core
// fixed pool of particles: emit, whole pool tick and slot read
// ----------------------------------------------------------------------------
// an item is taken on start while busy is low; busy stays high until the
// single result has been shown on the result ports with done_o for one cycle.
// the receiver cannot stall, so the result is simply dropped if unobserved.
// emit and read show their result through the slot ram read and then the
// result register; an unused operation answers in the next cycle.
// busy covers the result cycle, so the next item is taken in the cycle after it.
// a tick walks every slot in turn through one shared multiplier and one
// shared 33-step divider: an inactive slot takes a ram read and a check,
// a slot that dies adds a write back, a live slot takes ram read, check,
// two axis products, divide, five lerps and write back, the divide being
// skipped when its life runs out in this tick. after reset a clearing pass
// zeroes every slot, its active flag included, with busy held high; the
// write pointer starts at the top.
// ----------------------------------------------------------------------------
module particle_pool_update_core import ppu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] delta_time_i,
  input  logic [9:0]  slot_index_i,
  input  logic [31:0] start_position_i,
  input  logic [31:0] base_velocity_i,
  input  logic [31:0] velocity_jitter_i,
  input  logic [31:0] begin_rgba_i,
  input  logic [31:0] end_rgba_i,
  input  logic [15:0] begin_size_i,
  input  logic [15:0] end_size_i,
  input  logic [15:0] life_span_i,
  output logic [9:0]  slot_o,
  output logic        is_active_o,
  output logic [31:0] now_position_o,
  output logic [31:0] now_rgba_o,
  output logic [15:0] now_size_o,
  output logic [10:0] live_count_o
);
  `include "particle_pool_update_core_assert.svh"

  typedef enum logic [10:0] {
    StClr   = 11'b00000000001,
    StIdle  = 11'b00000000010,
    StEmWr  = 11'b00000000100,
    StRdOut = 11'b00000001000,
    StTkRd  = 11'b00000010000,
    StTkChk = 11'b00000100000,
    StTkMx  = 11'b00001000000,
    StTkMy  = 11'b00010000000,
    StTkDv  = 11'b00100000000,
    StTkLp  = 11'b01000000000,
    StTkWr  = 11'b10000000000
  } st_e;

  st_e st_q, st_d;
  logic [IdxW-1:0] wp_q, wp_d, idx_q, idx_d;
  logic [CntW-1:0] live_q, live_d;
  logic [15:0] dt_q, dt_d;
  logic [9:0]  rslot_q, rslot_d;
  rec_t        cur_q, cur_d;
  logic [16:0] f_q, f_d;
  logic [2:0]  lane_q, lane_d;
  logic        done_q, done_d;
  logic [9:0]  oslot_q, oslot_d;
  logic        oact_q, oact_d;
  logic [31:0] opos_q, opos_d, orgba_q, orgba_d;
  logic [15:0] osize_q, osize_d;

  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  rec_t ram_wdata, ram_rdata;
  div_req_t dreq;
  div_rsp_t drsp;

  ppu_ram #(.Width(RecW), .Depth(PoolSize)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  ppu_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // shared multiplier: signed 18 by 18
  logic signed [17:0] ma, mb;
  logic signed [35:0] mp;
  assign mp = ma * mb;

  logic signed [15:0] svx, svy;
  logic [16:0] dt_life;
  logic [15:0] lse, lsb;
  logic [34:0] lsum;
  logic [18:0] lres;
  logic signed [36:0] rnd;
  logic signed [17:0] npos;

  assign svx = sat16(18'(signed'(base_velocity_i[15:0])) +
                     18'(signed'(velocity_jitter_i[15:0])));
  assign svy = sat16(18'(signed'(base_velocity_i[31:16])) +
                     18'(signed'(velocity_jitter_i[31:16])));
  assign dt_life = (17'(dt_q) + 17'd128) >> 8;
  assign busy = (st_q != StIdle) || done_q;

  always_comb begin
    st_d = st_q; wp_d = wp_q; idx_d = idx_q; live_d = live_q;
    dt_d = dt_q; rslot_d = rslot_q; cur_d = cur_q; f_d = f_q;
    lane_d = lane_q; done_d = 1'b0; oslot_d = oslot_q; oact_d = oact_q;
    opos_d = opos_q; orgba_d = orgba_q; osize_d = osize_q;
    ram_we = 1'b0; ram_addr = idx_q; ram_wdata = cur_q;
    dreq = '0; ma = '0; mb = '0;
    lse = '0; lsb = '0; lsum = '0; lres = '0;
    rnd = '0; npos = '0;

    unique case (st_q)
      StClr: begin
        ram_we = 1'b1; ram_wdata = '0;
        if (idx_q == IdxW'(PoolSize - 1)) begin
          idx_d = '0; st_d = StIdle;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StIdle: begin
        if (start && !busy) begin
          unique case (op_e'(operation_i))
            OpEmit: begin
              // old record is read first to see whether the slot was live
              ram_addr = wp_q; idx_d = wp_q;
              cur_d.active = 1'b1;
              cur_d.px = start_position_i[15:0];
              cur_d.py = start_position_i[31:16];
              cur_d.vx = svx; cur_d.vy = svy;
              cur_d.begin_rgba = begin_rgba_i;
              cur_d.end_rgba = end_rgba_i;
              cur_d.cur_rgba = begin_rgba_i;
              cur_d.begin_size = begin_size_i;
              cur_d.end_size = end_size_i;
              cur_d.cur_size = begin_size_i;
              cur_d.life_span = life_span_i;
              cur_d.life_left = {1'b0, life_span_i};
              wp_d = (wp_q == '0) ? IdxW'(PoolSize - 1) : wp_q - 1'b1;
              st_d = StEmWr;
            end
            OpTick: begin
              dt_d = delta_time_i; idx_d = '0; st_d = StTkRd;
            end
            OpRead: begin
              ram_addr = slot_index_i; rslot_d = slot_index_i;
              st_d = StRdOut;
            end
            OpNone: begin
              oslot_d = '0; oact_d = 1'b0; opos_d = '0; orgba_d = '0;
              osize_d = '0; done_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      StEmWr: begin
        ram_we = 1'b1;
        if (!ram_rdata.active) live_d = live_q + 1'b1;
        oslot_d = idx_q; oact_d = 1'b1;
        opos_d = {cur_q.py, cur_q.px}; orgba_d = cur_q.cur_rgba;
        osize_d = cur_q.cur_size;
        done_d = 1'b1; st_d = StIdle;
      end
      StRdOut: begin
        oslot_d = rslot_q; oact_d = ram_rdata.active;
        opos_d = {ram_rdata.py, ram_rdata.px};
        orgba_d = ram_rdata.cur_rgba; osize_d = ram_rdata.cur_size;
        done_d = 1'b1; st_d = StIdle;
      end
      StTkRd: st_d = StTkChk;
      StTkChk: begin
        cur_d = ram_rdata;
        if (!ram_rdata.active) begin
          if (idx_q == IdxW'(PoolSize - 1)) begin
            oslot_d = '0; oact_d = 1'b0; opos_d = '0; orgba_d = '0;
            osize_d = '0; done_d = 1'b1; st_d = StIdle;
          end else begin
            idx_d = idx_q + 1'b1; st_d = StTkRd;
          end
        end else if (ram_rdata.life_left <= 17'sd0) begin
          cur_d.active = 1'b0; live_d = live_q - 1'b1;
          st_d = StTkWr;
        end else begin
          cur_d.life_left = ram_rdata.life_left - signed'(dt_life);
          st_d = StTkMx;
        end
      end
      StTkMx, StTkMy: begin
        ma = (st_q == StTkMx) ? 18'(cur_q.vx) : 18'(cur_q.vy);
        mb = signed'({2'b00, dt_q});
        rnd = 37'(mp) + 37'sd32768;
        npos = 18'(rnd >>> 16) +
               ((st_q == StTkMx) ? 18'(cur_q.px) : 18'(cur_q.py));
        if (st_q == StTkMx) begin
          cur_d.px = sat16(npos); st_d = StTkMy;
        end else begin
          cur_d.py = sat16(npos);
          if (cur_q.life_left > 17'sd0 && cur_q.life_span != '0) begin
            dreq.start = 1'b1;
            dreq.num = {cur_q.life_left[15:0], 16'h0000, 1'b0} >> 1;
            dreq.den = cur_q.life_span;
            st_d = StTkDv;
          end else begin
            f_d = '0; lane_d = '0; st_d = StTkLp;
          end
        end
      end
      StTkDv: begin
        if (drsp.done) begin
          f_d = (drsp.quo > 33'd65536) ? 17'd65536 : drsp.quo[16:0];
          lane_d = '0; st_d = StTkLp;
        end
      end
      StTkLp: begin
        // one channel per cycle, lane 4 is the size
        if (lane_q == 3'd4) begin
          lse = cur_q.end_size; lsb = cur_q.begin_size;
        end else begin
          lse = {8'h00, cur_q.end_rgba[lane_q[1:0]*8 +: 8]};
          lsb = {8'h00, cur_q.begin_rgba[lane_q[1:0]*8 +: 8]};
        end
        // end*(1-f) + begin*f as end + (begin-end)*f on the shared multiplier
        ma = 18'(signed'({2'b00, lsb}) - signed'({2'b00, lse}));
        mb = signed'({1'b0, f_q});
        lsum = {3'b000, lse, 16'h0000} + 35'(mp) + 35'd32768;
        lres = lsum[34:16];
        if (lane_q == 3'd4) begin
          cur_d.cur_size = (lres > 19'd65535) ? 16'hffff : lres[15:0];
          st_d = StTkWr;
        end else begin
          cur_d.cur_rgba[lane_q[1:0]*8 +: 8] = (lres > 19'd255) ? 8'hff : lres[7:0];
          lane_d = lane_q + 3'd1;
        end
      end
      StTkWr: begin
        ram_we = 1'b1;
        if (idx_q == IdxW'(PoolSize - 1)) begin
          oslot_d = '0; oact_d = 1'b0; opos_d = '0; orgba_d = '0;
          osize_d = '0; done_d = 1'b1; st_d = StIdle;
        end else begin
          idx_d = idx_q + 1'b1; st_d = StTkRd;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; wp_q <= IdxW'(PoolSize - 1);
      live_q <= '0; done_q <= 1'b0; idx_q <= '0; lane_q <= '0;
    end else begin
      st_q <= st_d; wp_q <= wp_d;
      live_q <= live_d; done_q <= done_d; idx_q <= idx_d; lane_q <= lane_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d; rslot_q <= rslot_d; cur_q <= cur_d;
    f_q <= f_d; oslot_q <= oslot_d; oact_q <= oact_d;
    opos_q <= opos_d; orgba_q <= orgba_d; osize_q <= osize_d;
  end

  assign done_o = done_q;
  assign slot_o = oslot_q;
  assign is_active_o = oact_q;
  assign now_position_o = opos_q;
  assign now_rgba_o = orgba_q;
  assign now_size_o = osize_q;
  assign live_count_o = live_q;

  `PPU_ASSERT(a_live_range, live_q <= CntW'(PoolSize), "live count above pool size")
  `PPU_ASSERT_NEXT(a_done_idle, done_q, st_q == StIdle, "result while sequencer busy")
  `PPU_ASSERT(a_onehot, $onehot(st_q), "state not one-hot")
endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks particle_pool_update_core: emits, whole-pool ticks, slot reads and no-ops
// are sent with random gaps, every result is compared against a local pool model
// ----------------------------------------------------------------------------
module tb import ppu_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;

  typedef struct {
    op_e         op;
    logic [15:0] dt;
    logic [9:0]  idx;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] jit;
    logic [31:0] rgba_b;
    logic [31:0] rgba_e;
    logic [15:0] size_b;
    logic [15:0] size_e;
    logic [15:0] span;
  } item_t;

  typedef struct {
    logic [9:0]  slot;
    logic        act;
    logic [31:0] pos;
    logic [31:0] rgba;
    logic [15:0] size;
    logic [10:0] cnt;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        done_o;
  logic [1:0]  operation_i = OpNone;
  logic [15:0] delta_time_i = '0;
  logic [9:0]  slot_index_i = '0;
  logic [31:0] start_position_i = '0;
  logic [31:0] base_velocity_i = '0;
  logic [31:0] velocity_jitter_i = '0;
  logic [31:0] begin_rgba_i = '0;
  logic [31:0] end_rgba_i = '0;
  logic [15:0] begin_size_i = '0;
  logic [15:0] end_size_i = '0;
  logic [15:0] life_span_i = '0;
  logic [9:0]  slot_o;
  logic        is_active_o;
  logic [31:0] now_position_o;
  logic [31:0] now_rgba_o;
  logic [15:0] now_size_o;
  logic [10:0] live_count_o;

  particle_pool_update_core u_top (.*);

  always #4 clk_i = ~clk_i;

  // local pool model
  rec_t        pool_rec[PoolSize];
  logic        pool_live[PoolSize];
  logic        pool_written[PoolSize];
  logic [9:0]  written_list[$];
  logic [9:0]  emit_ptr;
  int unsigned live_total;

  result_t     pending_q[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint mix(longint e, longint b, longint f, longint maxv);
    longint s;
    s = (e * (65536 - f) + b * f + 32768) >>> 16;
    return (s > maxv) ? maxv : s;
  endfunction

  function automatic void advance_slot(int unsigned i, logic [15:0] dt);
    rec_t   r;
    longint f;
    longint step;
    r = pool_rec[i];
    r.life_left = r.life_left - 17'(({1'b0, dt} + 17'd128) >> 8);
    step = (longint'(r.vx) * longint'(dt) + 32768) >>> 16;
    r.px = clamp16(longint'(r.px) + step);
    step = (longint'(r.vy) * longint'(dt) + 32768) >>> 16;
    r.py = clamp16(longint'(r.py) + step);
    f = 0;
    if (r.life_left > 0 && r.life_span != 0) begin
      f = (longint'(r.life_left) << 16) / longint'(r.life_span);
      if (f > 65536) f = 65536;
    end
    for (int k = 0; k < 4; k++) begin
      r.cur_rgba[8*k +: 8] = 8'(mix(r.end_rgba[8*k +: 8], r.begin_rgba[8*k +: 8], f, 255));
    end
    r.cur_size = 16'(mix(r.end_size, r.begin_size, f, 65535));
    pool_rec[i] = r;
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t res;
    rec_t    r;
    res = '{slot: '0, act: 1'b0, pos: '0, rgba: '0, size: '0, cnt: '0};
    case (it.op)
      OpEmit: begin
        r.px = it.pos[15:0];
        r.py = it.pos[31:16];
        r.vx = clamp16(longint'($signed(it.vel[15:0])) + longint'($signed(it.jit[15:0])));
        r.vy = clamp16(longint'($signed(it.vel[31:16])) + longint'($signed(it.jit[31:16])));
        r.begin_rgba = it.rgba_b;
        r.end_rgba = it.rgba_e;
        r.cur_rgba = it.rgba_b;
        r.begin_size = it.size_b;
        r.end_size = it.size_e;
        r.cur_size = it.size_b;
        r.life_span = it.span;
        r.life_left = {1'b0, it.span};
        pool_rec[emit_ptr] = r;
        if (!pool_live[emit_ptr]) begin
          pool_live[emit_ptr] = 1'b1;
          live_total++;
        end
        if (!pool_written[emit_ptr]) begin
          pool_written[emit_ptr] = 1'b1;
          written_list.push_back(emit_ptr);
        end
        res.slot = emit_ptr;
        res.act = 1'b1;
        res.pos = {r.py, r.px};
        res.rgba = r.cur_rgba;
        res.size = r.cur_size;
        emit_ptr = emit_ptr - 10'd1;  // wraps from 0 to the top slot
      end
      OpTick: begin
        for (int unsigned i = 0; i < PoolSize; i++) begin
          if (!pool_live[i]) continue;
          if (pool_rec[i].life_left <= 0) begin
            pool_live[i] = 1'b0;
            live_total--;
          end else begin
            advance_slot(i, it.dt);
          end
        end
      end
      OpRead: begin
        r = pool_rec[it.idx];
        res.slot = it.idx;
        res.act = pool_live[it.idx];
        res.pos = {r.py, r.px};
        res.rgba = r.cur_rgba;
        res.size = r.cur_size;
      end
      default: ;
    endcase
    res.cnt = 11'(live_total);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
      operation_i <= 2'($urandom);
    end
    @(negedge clk_i);
    start <= 1'b1;
    operation_i <= it.op;
    delta_time_i <= it.dt;
    slot_index_i <= it.idx;
    start_position_i <= it.pos;
    base_velocity_i <= it.vel;
    velocity_jitter_i <= it.jit;
    begin_rgba_i <= it.rgba_b;
    end_rgba_i <= it.rgba_e;
    begin_size_i <= it.size_b;
    end_size_i <= it.size_e;
    life_span_i <= it.span;
    // busy only moves on a rising edge, so its value here holds for the next edge
    while (busy) @(negedge clk_i);
    pending_q.push_back(apply_item(it));
    @(posedge clk_i);
  endtask

  function automatic item_t rand_item(op_e op);
    item_t it;
    it.op = op;
    it.dt = 16'($urandom);
    it.idx = 10'($urandom);
    it.pos = $urandom;
    it.vel = $urandom;
    it.jit = $urandom;
    it.rgba_b = $urandom;
    it.rgba_e = $urandom;
    it.size_b = 16'($urandom);
    it.size_e = 16'($urandom);
    // mostly short lives so the pool keeps draining
    it.span = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 2048)) : 16'($urandom);
    if (op == OpRead && written_list.size() != 0 && !pool_written[it.idx])
      it.idx = written_list[$urandom_range(0, written_list.size() - 1)];
    return it;
  endfunction

  task automatic send_emit(logic [31:0] pos, logic [31:0] vel, logic [31:0] jit,
                           logic [31:0] cb, logic [31:0] ce, logic [15:0] sb,
                           logic [15:0] se, logic [15:0] span);
    item_t it;
    it = rand_item(OpEmit);
    it.pos = pos; it.vel = vel; it.jit = jit;
    it.rgba_b = cb; it.rgba_e = ce;
    it.size_b = sb; it.size_e = se; it.span = span;
    send_item(it);
  endtask

  task automatic send_tick(logic [15:0] dt);
    item_t it;
    it = rand_item(OpTick);
    it.dt = dt;
    send_item(it);
  endtask

  task automatic send_read(logic [9:0] idx);
    item_t it;
    it = rand_item(OpRead);
    it.idx = idx;
    send_item(it);
  endtask

  // extremes of the fields, zero life, saturation and rounding
  task automatic test_directed();
    quiet = 1'b1;
    send_emit(32'h8000_7fff, 32'h7fff_7fff, 32'h7fff_0001, 32'hff00_ff00, 32'h00ff_00ff,
              16'hffff, 16'h0000, 16'hffff);
    send_emit(32'h7fff_8000, 32'h8000_8000, 32'h8000_ffff, 32'hffff_ffff, 32'h0000_0000,
              16'h0000, 16'hffff, 16'h0001);
    send_emit(32'h0000_0000, 32'h0100_ff00, 32'h0000_0000, 32'h1234_5678, 32'h89ab_cdef,
              16'h0180, 16'h0040, 16'h0000);
    send_emit(32'h0010_fff0, 32'h0003_fffd, 32'h0000_0000, 32'h8080_8080, 32'h0102_0304,
              16'h1000, 16'h2000, 16'h0200);
    send_read(10'd1023);
    send_read(10'd1020);
    send_tick(16'd0);
    send_tick(16'd128);
    send_tick(16'd127);
    send_read(10'd1023);
    send_read(10'd1022);
    send_read(10'd1021);
    send_read(10'd1020);
    send_tick(16'hffff);
    send_tick(16'h8000);
    send_read(10'd1020);
    begin
      item_t it;
      it = rand_item(OpNone);
      send_item(it);
    end
    send_tick(16'hffff);
    send_tick(16'hffff);
    send_read(10'd1023);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int unsigned pick;
    for (int n = 0; n < 270; n++) begin
      if (n % 60 == 0) quiet = ~quiet;
      pick = $urandom_range(0, 99);
      if (pick < 40) send_item(rand_item(OpEmit));
      else if (pick < 60) send_item(rand_item(OpTick));
      else if (pick < 95) send_item(rand_item(OpRead));
      else send_item(rand_item(OpNone));
    end
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, slot %0d", slot_o);
      end else begin
        want = pending_q.pop_front();
        if (slot_o !== want.slot || is_active_o !== want.act || now_position_o !== want.pos ||
            now_rgba_o !== want.rgba || now_size_o !== want.size ||
            live_count_o !== want.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp slot %0d act %0b pos %h rgba %h size %h cnt %0d",
                      " / got slot %0d act %0b pos %h rgba %h size %h cnt %0d"},
                     want.slot, want.act, want.pos, want.rgba, want.size, want.cnt,
                     slot_o, is_active_o, now_position_o, now_rgba_o, now_size_o,
                     live_count_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < PoolSize; i++) begin
      pool_rec[i] = '0;
      pool_live[i] = 1'b0;
      pool_written[i] = 1'b0;
    end
    emit_ptr = 10'(PoolSize - 1);
    live_total = 0;
    mismatches = 0;
    cycles = 0;
    quiet = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    wait (pending_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
